[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/slvi_pkg.sv]
// Types and constants of the slanted lenticular view index block.
`default_nettype none

package slvi_pkg;

    // Field and register widths
    localparam int COORD_W     = 12;
    localparam int VIEW_W      = 6;
    localparam int PITCH_W     = 23;
    localparam int OFFSET_W    = 24;
    localparam int SLANT_W     = 18;
    localparam int COUNT_W     = 7;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    // Datapath widths
    localparam int FRAC_W  = 16;                    // Q.16 fraction
    localparam int COL_W   = 14;                    // subpixel column, up to 3*4095+2
    localparam int PROD_W  = COORD_W + 1 + SLANT_W; // signed y*slant
    localparam int PHASE_W = 33;                    // signed phase
    localparam int MAG_W   = 32;                    // magnitude of the phase
    localparam int LANES   = 3;                     // red, green, blue

    localparam logic [PITCH_W-1:0] LENS_PITCH_RESET = 23'd327680;
    localparam logic [COUNT_W-1:0] VIEW_COUNT_RESET = 7'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LENS_PITCH   = 2'd0,
        REG_PHASE_OFFSET = 2'd1,
        REG_SLANT        = 2'd2,
        REG_VIEW_COUNT   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [VIEW_W-1:0] red_view;
        logic [VIEW_W-1:0] green_view;
        logic [VIEW_W-1:0] blue_view;
    } view_out_t;

    // Geometry settings used by the phase front end
    typedef struct packed {
        logic signed [OFFSET_W-1:0] phase_offset;
        logic signed [SLANT_W-1:0]  slant;
    } geom_cfg_t;

    typedef logic [LANES-1:0][MAG_W-1:0]   mag_lanes_t;
    typedef logic [LANES-1:0][PITCH_W-1:0] rem_lanes_t;

endpackage

`default_nettype wire

[rtl/slvi_front.sv]
// Phase front end: y*slant product, base phase, per-lane phase, sign and magnitude.
`default_nettype none

module slvi_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  slvi_pkg::pixel_in_t in_data,
    input  slvi_pkg::geom_cfg_t cfg,
    output logic                out_valid,
    output slvi_pkg::mag_lanes_t out_mag,
    output logic [slvi_pkg::LANES-1:0] out_neg
);
    import slvi_pkg::*;

    logic signed [PROD_W-1:0]          prod_next;
    logic [COL_W-1:0]                  col_next;
    logic signed [PHASE_W-1:0]         triple_prod;
    logic signed [PHASE_W-1:0]         base_next;
    logic [LANES-1:0][PHASE_W-1:0]     phase_next;
    mag_lanes_t                        mag_next;
    logic [LANES-1:0]                  neg_next;

    logic                              s1_valid_reg;
    logic signed [PROD_W-1:0]          s1_prod_reg;
    logic [COL_W-1:0]                  s1_col_reg;
    logic                              s2_valid_reg;
    logic signed [PHASE_W-1:0]         s2_base_reg;
    logic [COL_W-1:0]                  s2_col_reg;
    logic                              s3_valid_reg;
    logic [LANES-1:0][PHASE_W-1:0]     s3_phase_reg;
    logic                              s4_valid_reg;
    mag_lanes_t                        s4_mag_reg;
    logic [LANES-1:0]                  s4_neg_reg;

    // Stage 1: y*slant and the blue subpixel column 3x
    assign prod_next = $signed({1'b0, in_data.pixel_y}) * $signed(cfg.slant);
    assign col_next  = COL_W'(in_data.pixel_x) + (COL_W'(in_data.pixel_x) << 1);

    // Stage 2: offset minus 3*y*slant
    assign triple_prod = PHASE_W'(s1_prod_reg) + (PHASE_W'(s1_prod_reg) <<< 1);
    assign base_next   = PHASE_W'($signed(cfg.phase_offset)) - triple_prod;

    // Stage 3: add column in Q.16, lane 0 is red (3x+2), lane 2 is blue (3x)
    always_comb begin
        logic [COL_W-1:0] col_k;
        col_k = '0;
        for (int k = 0; k < LANES; k++) begin
            col_k = s2_col_reg + COL_W'(LANES - 1 - k);
            phase_next[k] = PHASE_W'($signed({1'b0, col_k, {FRAC_W{1'b0}}})) + s2_base_reg;
        end
    end

    // Stage 4: split into sign and magnitude for the remainder divider
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            neg_next[k] = s3_phase_reg[k][PHASE_W-1];
            if (neg_next[k]) begin
                mag_next[k] = MAG_W'(-s3_phase_reg[k]);
            end else begin
                mag_next[k] = s3_phase_reg[k][MAG_W-1:0];
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_prod_reg  <= prod_next;
            s1_col_reg   <= col_next;
            s2_base_reg  <= base_next;
            s2_col_reg   <= s1_col_reg;
            s3_phase_reg <= phase_next;
            s4_mag_reg   <= mag_next;
            s4_neg_reg   <= neg_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_mag   = s4_mag_reg;
    assign out_neg   = s4_neg_reg;

endmodule

`default_nettype wire

[rtl/slvi_rem_pipe.sv]
// Remainder of the phase magnitude by the lens pitch, one restoring step per stage.
`default_nettype none

module slvi_rem_pipe (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  slvi_pkg::mag_lanes_t         in_mag,
    input  logic [slvi_pkg::LANES-1:0]   in_neg,
    input  logic [slvi_pkg::PITCH_W-1:0] pitch,
    output logic                         out_valid,
    output slvi_pkg::rem_lanes_t         out_rem,
    output logic [slvi_pkg::LANES-1:0]   out_neg
);
    import slvi_pkg::*;

    logic [MAG_W-1:0] vld_reg;
    rem_lanes_t       rem_reg [MAG_W];
    mag_lanes_t       dvd_reg [MAG_W];
    logic [LANES-1:0] neg_reg [MAG_W];

    for (genvar s = 0; s < MAG_W; s++) begin : g_step
        logic             vld_in;
        rem_lanes_t       rem_in;
        mag_lanes_t       dvd_in;
        logic [LANES-1:0] neg_in;
        rem_lanes_t       rem_next;
        mag_lanes_t       dvd_next;

        if (s == 0) begin : g_head
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign dvd_in = in_mag;
            assign neg_in = in_neg;
        end else begin : g_body
            assign vld_in = vld_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign dvd_in = dvd_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end

        // Shift in the next dividend bit, subtract the pitch when it fits
        always_comb begin
            logic [PITCH_W:0] trial;
            trial = '0;
            for (int k = 0; k < LANES; k++) begin
                trial = {rem_in[k], dvd_in[k][MAG_W-1]};
                if (trial >= {1'b0, pitch}) begin
                    rem_next[k] = PITCH_W'(trial - {1'b0, pitch});
                end else begin
                    rem_next[k] = trial[PITCH_W-1:0];
                end
                dvd_next[k] = dvd_in[k] << 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                dvd_reg[s] <= dvd_next;
                neg_reg[s] <= neg_in;
            end
        end
    end

    assign out_valid = vld_reg[MAG_W-1];
    assign out_rem   = rem_reg[MAG_W-1];
    assign out_neg   = neg_reg[MAG_W-1];

endmodule

`default_nettype wire

[rtl/slvi_view_pipe.sv]
// Floor-modulo fixup, scale by view count and divide by the pitch into a view index.
`default_nettype none

module slvi_view_pipe #(
    parameter int MAX_VIEW_COUNT = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  slvi_pkg::rem_lanes_t         in_rem,
    input  logic [slvi_pkg::LANES-1:0]   in_neg,
    input  logic [slvi_pkg::PITCH_W-1:0] pitch,
    input  logic                         pitch_zero,
    input  logic [$clog2(MAX_VIEW_COUNT+1)-1:0] count,
    output logic                         out_valid,
    output logic [slvi_pkg::LANES-1:0][$clog2(MAX_VIEW_COUNT)-1:0] out_view
);
    import slvi_pkg::*;

    localparam int CNTW  = $clog2(MAX_VIEW_COUNT + 1);
    localparam int QW    = $clog2(MAX_VIEW_COUNT);
    localparam int PRODW = PITCH_W + CNTW;

    typedef logic [LANES-1:0][QW-1:0]    quo_lanes_t;
    typedef logic [LANES-1:0][PRODW-1:0] prod_lanes_t;

    rem_lanes_t  r_next;
    prod_lanes_t prod_next;

    logic        v1_valid_reg;
    rem_lanes_t  v1_r_reg;
    logic        v2_valid_reg;
    prod_lanes_t v2_prod_reg;

    logic [QW-1:0] vld_reg;
    rem_lanes_t    drem_reg [QW];
    quo_lanes_t    low_reg  [QW];
    quo_lanes_t    quo_reg  [QW];

    // Floor modulo: a negative phase with nonzero remainder wraps to pitch - rem
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (in_neg[k] && (in_rem[k] != '0)) begin
                r_next[k] = pitch - in_rem[k];
            end else begin
                r_next[k] = in_rem[k];
            end
        end
    end

    // r * count
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            prod_next[k] = PRODW'(v1_r_reg[k]) * PRODW'(count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
        end else if (en) begin
            v1_valid_reg <= in_valid;
            v2_valid_reg <= v1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_r_reg    <= r_next;
            v2_prod_reg <= prod_next;
        end
    end

    // Quotient of r*count by pitch, one bit per stage; the top part is already below pitch
    for (genvar s = 0; s < QW; s++) begin : g_step
        logic       vld_in;
        rem_lanes_t rem_in;
        quo_lanes_t low_in;
        quo_lanes_t quo_in;
        rem_lanes_t rem_next;
        quo_lanes_t low_next;
        quo_lanes_t quo_next;

        if (s == 0) begin : g_head
            assign vld_in = v2_valid_reg;
            always_comb begin
                for (int k = 0; k < LANES; k++) begin
                    rem_in[k] = v2_prod_reg[k][QW +: PITCH_W];
                    low_in[k] = v2_prod_reg[k][QW-1:0];
                end
            end
            assign quo_in = '0;
        end else begin : g_body
            assign vld_in = vld_reg[s-1];
            assign rem_in = drem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb begin
            logic [PITCH_W:0] trial;
            logic             qbit;
            trial = '0;
            qbit  = 1'b0;
            for (int k = 0; k < LANES; k++) begin
                trial = {rem_in[k], low_in[k][QW-1]};
                qbit  = (trial >= {1'b0, pitch});
                if (qbit) begin
                    rem_next[k] = PITCH_W'(trial - {1'b0, pitch});
                end else begin
                    rem_next[k] = trial[PITCH_W-1:0];
                end
                low_next[k] = low_in[k] << 1;
                quo_next[k] = (quo_in[k] << 1) | QW'(qbit);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[s] <= rem_next;
                low_reg[s]  <= low_next;
                quo_reg[s]  <= quo_next;
            end
        end
    end

    // Zero pitch gives view 0; clamp to count-1
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (pitch_zero) begin
                out_view[k] = '0;
            end else if (CNTW'(quo_reg[QW-1][k]) >= count) begin
                out_view[k] = QW'(count - 1'b1);
            end else begin
                out_view[k] = quo_reg[QW-1][k];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];

endmodule

`default_nettype wire

[rtl/slanted_lenticular_view_index.sv]
// Top level of the slanted lenticular view index block.
//
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   pixel_in_t  (pixel_x, pixel_y)
//  m_       out  m_valid / m_ready   view_out_t  (red_view, green_view, blue_view)
//  cfg_wr_  in   cfg_wr_en           cfg_wr_index, cfg_wr_data
//
//  One transaction per clock cycle while no result is stalled; data runs through the
//  front end, the 32-step remainder divider, the view divider and the output register.
//  aresetn is synchronous, active low; it clears valid bits and loads register defaults.
//  A stalled result freezes the whole pipeline; a one-entry input skid still takes
//  one more transaction, and s_ready comes straight from a register.
`default_nettype none

module slanted_lenticular_view_index #(
    parameter int MAX_VIEW_COUNT = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  slvi_pkg::pixel_in_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output slvi_pkg::view_out_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [slvi_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [slvi_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import slvi_pkg::*;

    localparam int CNTW = $clog2(MAX_VIEW_COUNT + 1);
    localparam int QW   = $clog2(MAX_VIEW_COUNT);

    // Configuration registers
    logic [PITCH_W-1:0]         lens_pitch_reg;
    logic signed [OFFSET_W-1:0] phase_offset_reg;
    logic signed [SLANT_W-1:0]  slant_reg;
    logic [COUNT_W-1:0]         view_count_reg;

    logic [CNTW-1:0] count_eff;
    logic            pitch_zero;
    geom_cfg_t       geom;

    // Handshake and skid
    logic      en;
    logic      s_fire;
    logic      skid_valid_reg;
    pixel_in_t skid_data_reg;
    logic      front_in_valid;
    pixel_in_t front_in_data;

    // Pipeline links
    logic                        front_valid;
    mag_lanes_t                  front_mag;
    logic [LANES-1:0]            front_neg;
    logic                        rem_valid;
    rem_lanes_t                  rem_lanes;
    logic [LANES-1:0]            rem_neg;
    logic                        view_valid;
    logic [LANES-1:0][QW-1:0]    view_lanes;

    logic      m_valid_reg;
    view_out_t m_data_reg;
    view_out_t m_data_next;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lens_pitch_reg   <= LENS_PITCH_RESET;
            phase_offset_reg <= '0;
            slant_reg        <= '0;
            view_count_reg   <= VIEW_COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                REG_LENS_PITCH:   lens_pitch_reg   <= cfg_wr_data[PITCH_W-1:0];
                REG_PHASE_OFFSET: phase_offset_reg <= $signed(cfg_wr_data[OFFSET_W-1:0]);
                REG_SLANT:        slant_reg        <= $signed(cfg_wr_data[SLANT_W-1:0]);
                REG_VIEW_COUNT:   view_count_reg   <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective view count: zero counts as one, capped at the maximum
    always_comb begin
        if (view_count_reg == '0) begin
            count_eff = CNTW'(1);
        end else if (32'(view_count_reg) > MAX_VIEW_COUNT) begin
            count_eff = CNTW'(MAX_VIEW_COUNT);
        end else begin
            count_eff = CNTW'(view_count_reg);
        end
    end

    assign pitch_zero        = (lens_pitch_reg == '0);
    assign geom.phase_offset = phase_offset_reg;
    assign geom.slant        = slant_reg;

    // Pipeline advances unless a result is waiting
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;

    // Input skid: catches one transaction while the pipeline is frozen
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_fire) begin
            skid_data_reg <= s_data;
        end
    end

    assign front_in_valid = skid_valid_reg || s_fire;
    assign front_in_data  = skid_valid_reg ? skid_data_reg : s_data;

    slvi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_in_valid),
        .in_data   (front_in_data),
        .cfg       (geom),
        .out_valid (front_valid),
        .out_mag   (front_mag),
        .out_neg   (front_neg)
    );

    slvi_rem_pipe u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_mag    (front_mag),
        .in_neg    (front_neg),
        .pitch     (lens_pitch_reg),
        .out_valid (rem_valid),
        .out_rem   (rem_lanes),
        .out_neg   (rem_neg)
    );

    slvi_view_pipe #(
        .MAX_VIEW_COUNT (MAX_VIEW_COUNT)
    ) u_view (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (rem_valid),
        .in_rem     (rem_lanes),
        .in_neg     (rem_neg),
        .pitch      (lens_pitch_reg),
        .pitch_zero (pitch_zero),
        .count      (count_eff),
        .out_valid  (view_valid),
        .out_view   (view_lanes)
    );

    // Output register, low 6 bits of each view
    always_comb begin
        m_data_next.red_view   = VIEW_W'(view_lanes[0]);
        m_data_next.green_view = VIEW_W'(view_lanes[1]);
        m_data_next.blue_view  = VIEW_W'(view_lanes[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= view_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/slvi_checker.sv]
// Port-level checker for the view index block, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module slvi_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input slvi_pkg::view_out_t m_data
);
    import slvi_pkg::*;

    // A waiting result is held
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `ASSERT_CLKD(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data), "result changed while stalled")

    // Input side backs off only after a stalled result
    `ASSERT_CLKD(a_ready_low, aclk, aresetn, !s_ready |-> $past(m_valid && !m_ready), "input stalled with free output")

    // Reset empties the pipeline and the skid
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "not empty after reset")

endmodule

bind slanted_lenticular_view_index slvi_checker u_slvi_checker (.*);

`default_nettype wire

[tb/sv/slanted_lenticular_view_index_tb.sv]
// Self-checking testbench for the slanted lenticular view index block.
`timescale 1ns / 1ps

module slanted_lenticular_view_index_tb;
    import slvi_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int VIEW_LIMIT     = 64;
    localparam int DRAIN_CYCLES   = 60;      // extra wait after the last owed result
    localparam int TIMEOUT_CYCLES = 250000;
    localparam int RANDOM_ROUNDS  = 10;
    localparam int ROUND_PIXELS   = 40;

    // Tracks register settings and the view indices still owed by the block
    class lens_view_scoreboard;
        logic [PITCH_W-1:0]         lens_pitch;
        logic signed [OFFSET_W-1:0] phase_offset;
        logic signed [SLANT_W-1:0]  slant;
        logic [COUNT_W-1:0]         view_count;
        view_out_t                  expected_views[$];
        int                         mismatches;

        function new();
            lens_pitch   = LENS_PITCH_RESET;
            phase_offset = '0;
            slant        = '0;
            view_count   = VIEW_COUNT_RESET;
            mismatches   = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_LENS_PITCH:   lens_pitch   = value[PITCH_W-1:0];
                REG_PHASE_OFFSET: phase_offset = value[OFFSET_W-1:0];
                REG_SLANT:        slant        = value[SLANT_W-1:0];
                REG_VIEW_COUNT:   view_count   = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // View index seen at one subpixel column of one row
        function logic [VIEW_W-1:0] view_for_column(longint col, longint row);
            longint pitch, off, sl, views, phase, rem, idx;
            pitch = longint'(lens_pitch);
            off   = longint'(phase_offset);
            sl    = longint'(slant);
            views = longint'(view_count);
            if (pitch == 0)
                return '0;
            if (views == 0)
                views = 1;
            if (views > VIEW_LIMIT)
                views = VIEW_LIMIT;
            phase = col * 65536 + off - 3 * row * sl;
            rem   = phase % pitch;
            if (rem < 0)
                rem += pitch;
            idx = (rem * views) / pitch;
            if (idx >= views)
                idx = views - 1;
            return idx[VIEW_W-1:0];
        endfunction

        function void note_pixel(pixel_in_t px);
            longint    x, y;
            view_out_t views;
            x = longint'(px.pixel_x);
            y = longint'(px.pixel_y);
            views.red_view   = view_for_column(3 * x + 2, y);
            views.green_view = view_for_column(3 * x + 1, y);
            views.blue_view  = view_for_column(3 * x, y);
            expected_views.push_back(views);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_views(view_out_t got);
            view_out_t want;
            if (expected_views.size() == 0) begin
                report_mismatch($sformatf("result %h with no pixel pending", got));
                return;
            end
            want = expected_views.pop_front();
            if (got.red_view != want.red_view)
                report_mismatch($sformatf("red_view %0d, want %0d",
                                          got.red_view, want.red_view));
            if (got.green_view != want.green_view)
                report_mismatch($sformatf("green_view %0d, want %0d",
                                          got.green_view, want.green_view));
            if (got.blue_view != want.blue_view)
                report_mismatch($sformatf("blue_view %0d, want %0d",
                                          got.blue_view, want.blue_view));
        endtask
    endclass

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    pixel_in_t              s_data       = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    view_out_t              m_data;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    lens_view_scoreboard sb = new();

    // Corner and pattern coordinates
    logic [COORD_W-1:0] probe_x [6] = '{12'd0, 12'd4095, 12'd3839, 12'd0, 12'd4095, 12'hAAA};
    logic [COORD_W-1:0] probe_y [6] = '{12'd0, 12'd4095, 12'd2159, 12'd4095, 12'd0, 12'h555};

    slanted_lenticular_view_index #(
        .MAX_VIEW_COUNT(VIEW_LIMIT)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    // Result side: check each transaction, then pick ready for the next cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_views(m_data);
            m_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
        end
    end

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(input logic [PITCH_W-1:0]  pitch,
                                  input logic [OFFSET_W-1:0] offset,
                                  input logic [SLANT_W-1:0]  slant_bits,
                                  input logic [COUNT_W-1:0]  views);
        write_register(REG_LENS_PITCH, CFG_DATA_W'(pitch));
        write_register(REG_PHASE_OFFSET, offset);
        write_register(REG_SLANT, CFG_DATA_W'(slant_bits));
        write_register(REG_VIEW_COUNT, CFG_DATA_W'(views));
        cfg_wr_en <= 1'b0;
    endtask

    // Idle cycles at the sender's rate, then hold the pixel until the block takes it
    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        pixel_in_t px;
        px.pixel_x = x;
        px.pixel_y = y;
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
    endtask

    // Let every owed result come out before touching the registers
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (sb.expected_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_round();
        logic [PITCH_W-1:0]  pitch;
        logic [SLANT_W-1:0]  slant_bits;
        logic [COUNT_W-1:0]  views;
        logic [COORD_W-1:0]  x, y;
        int                  pick;
        pick = $urandom_range(9, 0);
        if (pick == 0)
            pitch = PITCH_W'($urandom_range(65535, 1));
        else if (pick == 1)
            pitch = PITCH_W'($urandom);
        else
            pitch = PITCH_W'($urandom_range(1048576, 65536));
        if ($urandom_range(9, 0) < 8)
            slant_bits = SLANT_W'(int'($urandom_range(131072, 0)) - 65536);
        else
            slant_bits = SLANT_W'($urandom);
        if ($urandom_range(9, 0) < 8)
            views = COUNT_W'($urandom_range(64, 1));
        else
            views = COUNT_W'($urandom_range(127, 0));
        apply_settings(pitch, OFFSET_W'($urandom), slant_bits, views);
        for (int i = 0; i < ROUND_PIXELS; i++) begin
            if ($urandom_range(9, 0) < 8) begin
                x = COORD_W'($urandom_range(3839, 0));
                y = COORD_W'($urandom_range(2159, 0));
            end else begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            send_pixel(x, y);
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_idle_pct   = 37;
        receiver_idle_pct = 56;

        // Reset defaults with corner coordinates
        for (int i = 0; i < 6; i++)
            send_pixel(probe_x[i], probe_y[i]);
        wait_for_drain();

        // Zero pitch: all views zero
        apply_settings(23'd0, 24'h123456, 18'h01000, 7'd8);
        for (int i = 0; i < 4; i++)
            send_pixel(probe_x[i], probe_y[i]);
        wait_for_drain();

        // Pitch below one subpixel, zero view count, most negative offset and slant
        apply_settings(23'd1, 24'h800000, 18'h20000, 7'd0);
        for (int i = 0; i < 4; i++)
            send_pixel(probe_x[i], probe_y[i]);
        wait_for_drain();

        // Largest pitch, offset and slant; view count above the maximum
        apply_settings(23'h7FFFFF, 24'h7FFFFF, 18'h1FFFF, 7'd127);
        for (int i = 0; i < 4; i++)
            send_pixel(probe_x[i], probe_y[i]);
        wait_for_drain();

        // One subpixel pitch, full view count, slant of one
        apply_settings(23'd65536, 24'h000000, 18'h10000, 7'd64);
        for (int i = 0; i < 4; i++)
            send_pixel(probe_x[i], probe_y[i]);
        wait_for_drain();

        // Random settings and pixels; idling pattern changes per third
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            if (r == 4) begin
                sender_idle_pct   = 56;
                receiver_idle_pct = 37;
            end else if (r == 7) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            random_round();
        end

        if (sb.mismatches == 0 && sb.expected_views.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("simulation failed");
        $finish;
    end

endmodule
